// ----- hdl/xsp_pkg.sv -----
// shared types and constants of the xoshiro256++ generator
package xsp_pkg;

   localparam int WORD_W = 64;

   // item kinds carried in req_tuser
   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_RESEED = 1'b1;

   // output_format register codes
   localparam logic [1:0] FMT_RAW    = 2'd0;
   localparam logic [1:0] FMT_DOUBLE = 2'd1;
   localparam logic [1:0] FMT_FLOAT  = 2'd2;

   // splitmix64 constants
   localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;
   localparam int SM_SHIFT1 = 30;
   localparam int SM_SHIFT2 = 27;
   localparam int SM_SHIFT3 = 31;

   // xoshiro256++ shift and rotate amounts
   localparam int ROT_SUM = 23;
   localparam int SHL_T   = 17;
   localparam int ROT_W3  = 45;

   // one queued item after classification
   typedef struct packed {
      logic        reseed;
      logic [63:0] seed;
   } item_type;

   // one draw handed from the state core to the formatter
   typedef struct packed {
      logic        valid;
      logic [63:0] sum;
      logic [63:0] base;
   } draw_type;

endpackage

// ----- hdl/xoshiro256pp_generator.sv -----
// top level of the xoshiro256++ generator: input queue, state core, output pipeline
// a draw request passes the queue, and its word the s1, s2, s3 and output registers
// throughput: one draw per cycle unless the output stalls; a reseed holds the core
//    to take the item and expand four words through one shared 32x32 multiplier
// reset: synchronous, active high; after release the core expands seed zero,
//    during which request beats fill the queue but no draw is issued
module xoshiro256pp_generator import xsp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // seed_value
   input  logic        req_tuser,    // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // random_word
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data   // output_format
);

   logic [1:0] output_format_ff;
   logic       head_valid;
   item_type   head;
   logic       pop;
   logic       draw_ready;
   draw_type   draw;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_format_ff <= FMT_RAW;
      end else if (csr_wr_en) begin
         output_format_ff <= csr_wr_data;
      end
   end

   xsp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   xsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .draw_ready (draw_ready),
      .draw       (draw)
   );

   xsp_format u_format (
      .clock      (clock),
      .reset      (reset),
      .draw       (draw),
      .fmt        (output_format_ff),
      .draw_ready (draw_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hdl/xsp_front.sv -----
// input queue: takes request beats, classifies them and holds them for the core
module xsp_front import xsp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // seed_value
   input  logic        req_tuser,   // kind
   input  logic        pop,
   output logic        head_valid,
   output item_type    head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   item_type           item;

   assign req_tready  = (count_ff != CNT_W'(DEPTH));
   assign push        = req_tvalid && req_tready;
   assign item        = '{reseed: (req_tuser == KIND_RESEED), seed: req_tdata};

   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- hdl/xsp_core.sv -----
// state core: xoshiro256++ state update and splitmix64 seeding sequencer
module xsp_core import xsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  item_type head,
   output logic     pop,
   input  logic     draw_ready,
   output draw_type draw
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SEED = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_MIX  = 4'b1000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [63:0]    words_ff [4];
   logic [63:0]    words_in [4];
   logic [63:0]    seed_ff, seed_in;
   logic [63:0]    z_ff, z_in;
   logic [63:0]    acc_ff, acc_in;
   logic [63:0]    prod_ff, prod_in;
   logic           prod_hi_ff, prod_hi_in;
   logic [1:0]     part_ff, part_in;
   logic           round_ff, round_in;
   logic [1:0]     idx_ff, idx_in;

   logic [63:0]    seed_next;
   logic [63:0]    mul_k;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    product;
   logic [63:0]    w3_mix;

   assign seed_next = seed_ff + SM_GAMMA;
   assign mul_k     = round_ff ? SM_MUL2 : SM_MUL1;

   // low 64 bits of z * k from three 32x32 partial products
   always_comb begin
      case (part_ff)
         2'd0: begin
            mul_a = z_ff[31:0];
            mul_b = mul_k[31:0];
         end
         2'd1: begin
            mul_a = z_ff[63:32];
            mul_b = mul_k[31:0];
         end
         default: begin
            mul_a = z_ff[31:0];
            mul_b = mul_k[63:32];
         end
      endcase
   end

   assign product = {32'h0, mul_a} * {32'h0, mul_b};
   assign w3_mix  = words_ff[3] ^ words_ff[1];

   always_comb begin
      state_in   = state_ff;
      words_in   = words_ff;
      seed_in    = seed_ff;
      z_in       = z_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      prod_hi_in = prod_hi_ff;
      part_in    = part_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      draw.valid = 1'b0;
      draw.sum   = words_ff[0] + words_ff[3];
      draw.base  = words_ff[0];
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head.reseed) begin
                  pop      = 1'b1;
                  seed_in  = head.seed;
                  idx_in   = 2'd0;
                  state_in = ST_SEED;
               end else if (draw_ready) begin
                  pop         = 1'b1;
                  draw.valid  = 1'b1;
                  words_in[0] = words_ff[0] ^ w3_mix;
                  words_in[1] = words_ff[1] ^ words_ff[2] ^ words_ff[0];
                  words_in[2] = words_ff[2] ^ words_ff[0] ^ (words_ff[1] << SHL_T);
                  words_in[3] = (w3_mix << ROT_W3) | (w3_mix >> (WORD_W - ROT_W3));
               end
            end
         end
         ST_SEED: begin
            seed_in  = seed_next;
            z_in     = seed_next ^ (seed_next >> SM_SHIFT1);
            acc_in   = '0;
            part_in  = 2'd0;
            round_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            part_in = part_ff + 2'd1;
            if (part_ff != 2'd3) begin
               prod_in    = product;
               prod_hi_in = (part_ff != 2'd0);
            end
            // product registered in prod_ff, then accumulated
            if (part_ff != 2'd0) begin
               acc_in = acc_ff + (prod_hi_ff ? {prod_ff[31:0], 32'h0} : prod_ff);
            end
            if (part_ff == 2'd3) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (!round_ff) begin
               z_in     = acc_ff ^ (acc_ff >> SM_SHIFT2);
               round_in = 1'b1;
               acc_in   = '0;
               part_in  = 2'd0;
               state_in = ST_MUL;
            end else begin
               words_in[idx_ff] = acc_ff ^ (acc_ff >> SM_SHIFT3);
               round_in         = 1'b0;
               if (idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_SEED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // reset expands seed zero through the same sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED;
         seed_ff  <= '0;
         idx_ff   <= 2'd0;
         round_ff <= 1'b0;
         part_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         idx_ff   <= idx_in;
         round_ff <= round_in;
         part_ff  <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff   <= words_in;
      z_ff       <= z_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      prod_hi_ff <= prod_hi_in;
   end

endmodule

// ----- hdl/xsp_format.sv -----
// output pipeline: finishes the draw word, normalizes float fields and holds the response beat
module xsp_format import xsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  draw_type    draw,
   input  logic [1:0]  fmt,
   output logic        draw_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // random_word
);

   function automatic logic [5:0] top_bit52(input logic [51:0] m);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 52; i++) begin
         if (m[i]) p = 6'(i);
      end
      return p;
   endfunction

   function automatic logic [4:0] top_bit23(input logic [22:0] m);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 23; i++) begin
         if (m[i]) p = 5'(i);
      end
      return p;
   endfunction

   function automatic logic [63:0] pack_double(input logic [51:0] m, input logic [5:0] p,
                                               input logic is_zero);
      logic [52:0] shifted;
      logic [10:0] expo;
      shifted = {1'b0, m} << (6'd52 - p);
      expo    = 11'd971 + {5'b0, p};
      return is_zero ? 64'h0 : {1'b0, expo, shifted[51:0]};
   endfunction

   function automatic logic [31:0] pack_float(input logic [22:0] m, input logic [4:0] p,
                                              input logic is_zero);
      logic [23:0] shifted;
      logic [7:0]  expo;
      shifted = {1'b0, m} << (5'd23 - p);
      expo    = 8'd104 + {3'b0, p};
      return is_zero ? 32'h0 : {1'b0, expo, shifted[22:0]};
   endfunction

   logic        advance;

   logic        s1_valid_ff;
   logic [63:0] s1_sum_ff, s1_base_ff;
   logic [1:0]  s1_fmt_ff;

   logic        s2_valid_ff;
   logic [63:0] s2_word_ff, s2_word_in;
   logic [1:0]  s2_fmt_ff;

   logic        s3_valid_ff;
   logic [63:0] s3_word_ff;
   logic [1:0]  s3_fmt_ff;
   logic [5:0]  s3_top_d_ff, s3_top_d_in;
   logic [4:0]  s3_top_lo_ff, s3_top_lo_in;
   logic [4:0]  s3_top_hi_ff, s3_top_hi_in;
   logic        s3_zero_d_ff, s3_zero_d_in;
   logic        s3_zero_lo_ff, s3_zero_lo_in;
   logic        s3_zero_hi_ff, s3_zero_hi_in;

   logic        out_valid_ff;
   logic [63:0] out_data_ff, out_data_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign draw_ready = advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign s2_word_in = ((s1_sum_ff << ROT_SUM) | (s1_sum_ff >> (WORD_W - ROT_SUM)))
                       + s1_base_ff;

   assign s3_top_d_in   = top_bit52(s2_word_ff[63:12]);
   assign s3_top_lo_in  = top_bit23(s2_word_ff[22:0]);
   assign s3_top_hi_in  = top_bit23(s2_word_ff[54:32]);
   assign s3_zero_d_in  = (s2_word_ff[63:12] == '0);
   assign s3_zero_lo_in = (s2_word_ff[22:0] == '0);
   assign s3_zero_hi_in = (s2_word_ff[54:32] == '0);

   always_comb begin
      case (s3_fmt_ff)
         FMT_DOUBLE: out_data_in = pack_double(s3_word_ff[63:12], s3_top_d_ff, s3_zero_d_ff);
         FMT_FLOAT:  out_data_in = {pack_float(s3_word_ff[54:32], s3_top_hi_ff, s3_zero_hi_ff),
                                    pack_float(s3_word_ff[22:0], s3_top_lo_ff, s3_zero_lo_ff)};
         default:    out_data_in = s3_word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= draw.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_ff     <= draw.sum;
         s1_base_ff    <= draw.base;
         s1_fmt_ff     <= fmt;
         s2_word_ff    <= s2_word_in;
         s2_fmt_ff     <= s1_fmt_ff;
         s3_word_ff    <= s2_word_ff;
         s3_fmt_ff     <= s2_fmt_ff;
         s3_top_d_ff   <= s3_top_d_in;
         s3_top_lo_ff  <= s3_top_lo_in;
         s3_top_hi_ff  <= s3_top_hi_in;
         s3_zero_d_ff  <= s3_zero_d_in;
         s3_zero_lo_ff <= s3_zero_lo_in;
         s3_zero_hi_ff <= s3_zero_hi_in;
         out_data_ff   <= out_data_in;
      end
   end

endmodule

// ----- hdl/xsp_checker.sv -----
// port-level checks for the xoshiro256++ generator and their bind
module xsp_checker import xsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_wr_en,
   input logic [1:0]  csr_wr_data
);

   logic [7:0] outstanding_ff, outstanding_in;
   logic       draw_beat;
   logic       rsp_beat;

   assign draw_beat = req_tvalid && req_tready && (req_tuser == KIND_DRAW);
   assign rsp_beat  = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({draw_beat, rsp_beat})
         2'b10:   outstanding_in = outstanding_ff + 8'd1;
         2'b01:   outstanding_in = outstanding_ff - 8'd1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // a stalled response beat keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // every response belongs to an accepted draw; reseeds and config writes give none
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != 8'd0)
      else $error("response without an outstanding draw");

   // reset empties the output pipeline
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_wr_en, csr_wr_data};

endmodule

bind xoshiro256pp_generator xsp_checker u_checker (.*);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the xoshiro256++ generator with splitmix64 seeding
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import xsp_pkg::*;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
   localparam logic [1:0]  FMT_SPARE    = 2'd3;
   // a reseed keeps the core busy with no result to show for it,
   // and up to three of them can still sit in the queue and the core
   localparam int SETTLE_CYCLES   = 150;
   localparam int TAIL_CYCLES     = 20;
   localparam int HOLD_CYCLES     = 300;
   localparam int ZERO_SEARCH_CAP = 1 << 24;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;    // seed_value
   logic        req_tuser   = 1'b0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;           // random_word
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = '0;    // output_format

   // generator state and format as the block should hold them
   logic [63:0] gen_state [4];
   logic [1:0]  active_format;
   logic [63:0] pending_words [$];

   rx_mode_type rx_mode       = RX_RANDOM;
   int          hold_request  = 0;
   int          hold_left     = 0;
   int unsigned rx_cycle      = 0;
   int          draws_sent    = 0;
   int          reseeds_sent  = 0;
   int          results_checked = 0;
   int          fail_count    = 0;
   bit          zero_case_hit = 1'b0;
   bit [3:0]    formats_used  = '0;

   xoshiro256pp_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [63:0] rotl(logic [63:0] x, int k);
      return (x << k) | (x >> (64 - k));
   endfunction

   function automatic logic [63:0] mix64(logic [63:0] z);
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic void load_seed(logic [63:0] seed);
      int k;
      for (k = 0; k < 4; k++) begin
         seed = seed + GOLDEN_GAMMA;
         gen_state[k] = mix64(seed);
      end
   endfunction

   function automatic logic [63:0] advance_state();
      logic [63:0] a, b, word;
      a = gen_state[0];
      b = gen_state[1];
      word = rotl(a + gen_state[3], 23) + a;
      gen_state[2] ^= a;
      gen_state[3] ^= b;
      gen_state[1] ^= gen_state[2];
      gen_state[0] ^= gen_state[3];
      gen_state[2] ^= b << 17;
      gen_state[3] = rotl(gen_state[3], 45);
      return word;
   endfunction

   // m * 2^-52 exactly, normalized on its top set bit
   function automatic logic [63:0] unit_double(logic [51:0] m);
      int p, k;
      logic [51:0] frac;
      if (m == '0) return 64'd0;
      p = 0;
      for (k = 0; k < 52; k++) if (m[k]) p = k;
      frac = m << (52 - p);
      return {1'b0, 11'(971 + p), frac};
   endfunction

   // m * 2^-23 exactly, normalized on its top set bit
   function automatic logic [31:0] unit_float(logic [22:0] m);
      int p, k;
      logic [22:0] frac;
      if (m == '0) return 32'd0;
      p = 0;
      for (k = 0; k < 23; k++) if (m[k]) p = k;
      frac = m << (23 - p);
      return {1'b0, 8'(104 + p), frac};
   endfunction

   function automatic logic [63:0] format_word(logic [63:0] raw, logic [1:0] fmt);
      case (fmt)
         FMT_DOUBLE: return unit_double(raw[63:12]);
         FMT_FLOAT:  return {unit_float(raw[54:32]), unit_float(raw[22:0])};
         default:    return raw;
      endcase
   endfunction

   function automatic logic [63:0] pick_seed();
      case ($urandom_range(0, 9))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         3:       return ~(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // seeds j*gamma share three of their four words with their neighbor, so one mix per try
   task automatic find_zero_field_seed(output bit found, output logic [63:0] seed);
      logic [63:0] win [4];
      logic [63:0] arg, word;
      int trial, k;
      found = 1'b0;
      seed  = '0;
      arg   = '0;
      for (k = 0; k < 4; k++) begin
         arg += GOLDEN_GAMMA;
         win[k] = mix64(arg);
      end
      for (trial = 0; trial < ZERO_SEARCH_CAP && !found; trial++) begin
         word = rotl(win[0] + win[3], 23) + win[0];
         if (word[22:0] == '0 || word[54:32] == '0) begin
            found = 1'b1;
            seed  = GOLDEN_GAMMA * 64'(trial);
         end else begin
            arg += GOLDEN_GAMMA;
            win[0] = win[1];
            win[1] = win[2];
            win[2] = win[3];
            win[3] = mix64(arg);
         end
      end
   endtask

   // called at a rising edge; returns at the edge that took the beat
   task automatic send_item(logic kind, logic [63:0] seed);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_RESEED) begin
         load_seed(seed);
         reseeds_sent++;
      end else begin
         pending_words.push_back(format_word(advance_state(), active_format));
         draws_sent++;
      end
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic set_format(logic [1:0] fmt);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_format = fmt;
      formats_used[fmt] = 1'b1;
   endtask

   task automatic run_traffic(int count, bit with_gaps);
      int sent, burst, k;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (k = 0; k < burst && sent < count; k++) begin
            send_item(($urandom_range(0, 99) < 5) ? KIND_RESEED : KIND_DRAW, pick_seed());
            sent++;
         end
         if (with_gaps && $urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
      end
   endtask

   // draws from the seed-zero state, some offered while the core is still expanding it
   task automatic test_reset_state();
      rx_mode = RX_RANDOM;
      formats_used[FMT_RAW] = 1'b1;
      send_item(KIND_DRAW, 64'd0);
      send_item(KIND_DRAW, '1);
      send_item(KIND_DRAW, {$urandom, $urandom});
   endtask

   task automatic test_reseed_extremes();
      send_item(KIND_RESEED, 64'd0);
      send_item(KIND_DRAW, '1);
      send_item(KIND_RESEED, '1);
      send_item(KIND_DRAW, 64'd0);
      send_item(KIND_RESEED, 64'h8000_0000_0000_0000);
      send_item(KIND_DRAW, 64'h8000_0000_0000_0000);
      send_item(KIND_RESEED, 64'h5555_5555_5555_5555);
      send_item(KIND_DRAW, 64'haaaa_aaaa_aaaa_aaaa);
      // back-to-back reseeds, only the second one counts
      send_item(KIND_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(KIND_RESEED, 64'h0123_4567_89ab_cdef);
      send_item(KIND_DRAW, 64'h5555_5555_5555_5555);
   endtask

   task automatic test_output_formats();
      bit          found;
      logic [63:0] seed;
      set_format(FMT_DOUBLE);
      send_item(KIND_DRAW, pick_seed());
      send_item(KIND_DRAW, pick_seed());
      set_format(FMT_FLOAT);
      send_item(KIND_DRAW, pick_seed());
      send_item(KIND_DRAW, pick_seed());
      // a float field with a zero mantissa has to come out as +0.0
      find_zero_field_seed(found, seed);
      if (found) begin
         zero_case_hit = 1'b1;
         send_item(KIND_RESEED, seed);
         send_item(KIND_DRAW, pick_seed());
      end
      // the unused code falls back to the raw word
      set_format(FMT_SPARE);
      send_item(KIND_DRAW, pick_seed());
      send_item(KIND_DRAW, pick_seed());
   endtask

   // receiver holds off while the sender keeps offering, so the block fills and stalls
   task automatic test_long_hold();
      set_format(FMT_RAW);
      rx_mode = RX_RANDOM;
      hold_request = HOLD_CYCLES;
      run_traffic(60, 1'b0);
   endtask

   task automatic test_random_phases();
      set_format(FMT_RAW);
      rx_mode = RX_RANDOM;
      run_traffic(400, 1'b1);
      set_format(FMT_DOUBLE);
      rx_mode = RX_PATTERN;
      run_traffic(400, 1'b1);
      set_format(FMT_FLOAT);
      rx_mode = RX_ALWAYS;
      run_traffic(300, 1'b0);
      set_format(FMT_SPARE);
      rx_mode = RX_SPARSE;
      run_traffic(250, 1'b1);
      set_format(FMT_FLOAT);
      rx_mode = RX_RANDOM;
      run_traffic(300, 1'b1);
      set_format(FMT_DOUBLE);
      rx_mode = RX_ALWAYS;
      run_traffic(200, 1'b0);
   endtask

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= ((rx_cycle % 11) > 3);
            default:    rsp_tready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   always @(posedge clock) begin : check_beat
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t ns: random_word expected none actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            results_checked++;
            if (rsp_tdata !== want) begin
               $display("%0t ns: random_word expected %h actual %h", $time, want, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   initial begin
      load_seed(64'd0);
      active_format = FMT_RAW;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_reseed_extremes();
      test_output_formats();
      test_long_hold();
      test_random_phases();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d draws and %0d reseeds, %0d words checked, formats seen %b",
               draws_sent, reseeds_sent, results_checked, formats_used);
      $display("receiver held off %0d cycles once; zero-mantissa float draw %s",
               HOLD_CYCLES, zero_case_hit ? "exercised" : "not found");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/xsp_pkg.sv
hdl/xsp_front.sv
hdl/xsp_core.sv
hdl/xsp_format.sv
hdl/xoshiro256pp_generator.sv
hdl/xsp_checker.sv
tb/sv/tb_top.sv
